// File: rtl/core/gpcc_pkg.sv
// Shared types and constants of the grid pattern chain counter.
`default_nettype none

package gpcc_pkg;

    localparam int COUNT_W      = 63;
    localparam int SYM_W        = 8;
    localparam int SIZE_W       = 11;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 11;
    localparam int DEF_MAX_COLS = 1024;
    localparam int DEF_MAX_ROWS = 1024;

    // Reset values of the configuration registers.
    localparam logic [SIZE_W-1:0] RST_GRID_ROWS = 11'd1024;
    localparam logic [SIZE_W-1:0] RST_GRID_COLS = 11'd1024;
    localparam logic [SYM_W-1:0]  RST_FIRST     = 8'd58;
    localparam logic [SYM_W-1:0]  RST_SECOND    = 8'd45;
    localparam logic [SYM_W-1:0]  RST_THIRD     = 8'd41;

    typedef logic [COUNT_W-1:0] t_count;

    // The three dominance counts of one cell.
    typedef struct packed {
        t_count single;
        t_count pair;
        t_count triple;
    } t_counts;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GRID_ROWS     = 3'd0,
        REG_GRID_COLS     = 3'd1,
        REG_FIRST_SYMBOL  = 3'd2,
        REG_SECOND_SYMBOL = 3'd3,
        REG_THIRD_SYMBOL  = 3'd4
    } t_cfg_index;

    typedef struct packed {
        logic [SYM_W-1:0] sym_first;
        logic [SYM_W-1:0] sym_second;
        logic [SYM_W-1:0] sym_third;
    } t_symbols;

    // Per-cell control that travels with a cell into the update stage.
    typedef struct packed {
        logic has_above;
        logic has_left;
        logic last_cell;
        logic forward;
    } t_cell_ctl;

endpackage

`default_nettype wire

// File: rtl/core/gpcc_if.sv
// Stream interfaces for the cell input and the chain count output.
`default_nettype none

interface gpcc_cell_if;
    logic                        valid;
    logic                        ready;
    logic [gpcc_pkg::SYM_W-1:0]  cell_char;

    modport source (output valid, output cell_char, input ready);
    modport sink   (input valid, input cell_char, output ready);
endinterface

interface gpcc_count_if;
    logic             valid;
    logic             ready;
    gpcc_pkg::t_count chain_count;

    modport source (output valid, output chain_count, input ready);
    modport sink   (input valid, input chain_count, output ready);
endinterface

`default_nettype wire

// File: rtl/core/gpcc_cfg_regs.sv
// Configuration registers with grid size clamping.
`default_nettype none

module gpcc_cfg_regs #(
    parameter int MAX_ROWS = gpcc_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = gpcc_pkg::DEF_MAX_COLS,
    parameter int ROW_SZ_W = $clog2(MAX_ROWS + 1),
    parameter int COL_SZ_W = $clog2(MAX_COLS + 1)
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [gpcc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [gpcc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output logic      [ROW_SZ_W-1:0]               o_rows,
    output logic      [COL_SZ_W-1:0]               o_cols,
    output gpcc_pkg::t_symbols                     o_symbols
);

    localparam int RW = (ROW_SZ_W > gpcc_pkg::SIZE_W) ? ROW_SZ_W : gpcc_pkg::SIZE_W;
    localparam int CW = (COL_SZ_W > gpcc_pkg::SIZE_W) ? COL_SZ_W : gpcc_pkg::SIZE_W;

    logic [gpcc_pkg::SIZE_W-1:0] r_rows;
    logic [gpcc_pkg::SIZE_W-1:0] r_cols;
    gpcc_pkg::t_symbols          r_symbols;
    logic [RW-1:0]               rows_ext;
    logic [CW-1:0]               cols_ext;

    // Register writes; an unknown index is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows               <= gpcc_pkg::RST_GRID_ROWS;
            r_cols               <= gpcc_pkg::RST_GRID_COLS;
            r_symbols.sym_first  <= gpcc_pkg::RST_FIRST;
            r_symbols.sym_second <= gpcc_pkg::RST_SECOND;
            r_symbols.sym_third  <= gpcc_pkg::RST_THIRD;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                gpcc_pkg::REG_GRID_ROWS: begin
                    r_rows <= i_cfg_data[gpcc_pkg::SIZE_W-1:0];
                end
                gpcc_pkg::REG_GRID_COLS: begin
                    r_cols <= i_cfg_data[gpcc_pkg::SIZE_W-1:0];
                end
                gpcc_pkg::REG_FIRST_SYMBOL: begin
                    r_symbols.sym_first <= i_cfg_data[gpcc_pkg::SYM_W-1:0];
                end
                gpcc_pkg::REG_SECOND_SYMBOL: begin
                    r_symbols.sym_second <= i_cfg_data[gpcc_pkg::SYM_W-1:0];
                end
                gpcc_pkg::REG_THIRD_SYMBOL: begin
                    r_symbols.sym_third <= i_cfg_data[gpcc_pkg::SYM_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // A size of zero counts as one; a size above the maximum counts as the maximum.
    always_comb begin
        rows_ext = RW'(r_rows);
        cols_ext = CW'(r_cols);
        if (r_rows == '0) begin
            o_rows = ROW_SZ_W'(1);
        end else if (rows_ext > RW'(MAX_ROWS)) begin
            o_rows = ROW_SZ_W'(MAX_ROWS);
        end else begin
            o_rows = ROW_SZ_W'(rows_ext);
        end
        if (r_cols == '0) begin
            o_cols = COL_SZ_W'(1);
        end else if (cols_ext > CW'(MAX_COLS)) begin
            o_cols = COL_SZ_W'(MAX_COLS);
        end else begin
            o_cols = COL_SZ_W'(cols_ext);
        end
    end

    assign o_symbols = r_symbols;

endmodule

`default_nettype wire

// File: rtl/core/gpcc_row_mem.sv
// Row buffer memory with one write port and one registered read port.
`default_nettype none

module gpcc_row_mem #(
    parameter int DEPTH = gpcc_pkg::DEF_MAX_COLS,
    parameter int WIDTH = 3 * gpcc_pkg::COUNT_W,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // A read of the address written in the same cycle returns the old entry.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// File: rtl/core/gpcc_cell_update.sv
// Update stage: forms the three counts of a cell and keeps left and diagonal counts.
`default_nettype none

module gpcc_cell_update (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_fire,
    input  wire gpcc_pkg::t_cell_ctl         i_ctl,
    input  wire logic [gpcc_pkg::SYM_W-1:0]  i_cell,
    input  wire gpcc_pkg::t_symbols          i_symbols,
    input  wire gpcc_pkg::t_counts           i_above_mem,
    output gpcc_pkg::t_counts                o_result
);

    gpcc_pkg::t_counts r_left;
    gpcc_pkg::t_counts r_diag;
    gpcc_pkg::t_counts above;
    gpcc_pkg::t_counts left;
    gpcc_pkg::t_counts diag;

    // Select the neighbors; the previous cell's result stands in for a row
    // buffer entry that it wrote while this cell was being read.
    always_comb begin
        if (!i_ctl.has_above) begin
            above = '0;
        end else if (i_ctl.forward) begin
            above = r_left;
        end else begin
            above = i_above_mem;
        end
        left = i_ctl.has_left ? r_left : '0;
        diag = i_ctl.has_left ? r_diag : '0;
    end

    // Above plus left minus diagonal, plus the contribution of a matched symbol.
    always_comb begin
        o_result.single = above.single + left.single - diag.single
                        + gpcc_pkg::t_count'(i_cell == i_symbols.sym_first);
        o_result.pair   = above.pair + left.pair - diag.pair
                        + ((i_cell == i_symbols.sym_second) ? diag.single : '0);
        o_result.triple = above.triple + left.triple - diag.triple
                        + ((i_cell == i_symbols.sym_third) ? diag.pair : '0);
    end

    // The above counts of this cell become the diagonal of the next one.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
            r_diag <= '0;
        end else if (i_fire) begin
            r_left <= o_result;
            r_diag <= above;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/grid_pattern_chain_counter_top.sv
// Top level of the grid pattern chain counter.
//
// Cells arrive on i_cell, one character per beat, in raster order. The block
// counts chains of the three configured symbols whose row and column both
// strictly increase, and after the last cell of a grid it sends the count as
// one beat on o_count; the position counters then restart for the next grid.
// Configuration must be written through i_cfg_we / i_cfg_index / i_cfg_data
// only while the block is idle; the block itself does not enforce this.
// Throughput is one cell per clock unless a last cell waits on o_count. The
// row buffer read is launched at the edge that accepts a cell, its counts are
// written back as it leaves the update stage, and the count beat is registered.
// One read and one write port of the row buffer per cycle set that rate; a
// row of one column is served by forwarding the previous cell's result.
// Reset clears positions, left and diagonal counts and restores the default
// configuration; the row buffer needs no clearing. While a count beat waits
// on o_count, cells keep flowing; only the last cell of the next grid waits.
`default_nettype none

module grid_pattern_chain_counter_top #(
    parameter int MAX_COLS = gpcc_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = gpcc_pkg::DEF_MAX_ROWS
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [gpcc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [gpcc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    gpcc_cell_if.sink                             i_cell,
    gpcc_count_if.source                          o_count
);

    localparam int COL_W    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int ROW_W    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_SZ_W = $clog2(MAX_COLS + 1);
    localparam int ROW_SZ_W = $clog2(MAX_ROWS + 1);
    localparam int CMPC_W   = COL_SZ_W + 1;
    localparam int CMPR_W   = ROW_SZ_W + 1;

    logic [ROW_SZ_W-1:0]          rows;
    logic [COL_SZ_W-1:0]          cols;
    gpcc_pkg::t_symbols           symbols;

    logic [COL_W-1:0]             r_col_pos;
    logic [ROW_W-1:0]             r_row_pos;
    logic [CMPC_W-1:0]            col_next;
    logic [CMPR_W-1:0]            row_next;
    logic                         col_end;
    logic                         row_end;

    logic                         r_s1_valid;
    gpcc_pkg::t_cell_ctl          r_s1_ctl;
    logic [gpcc_pkg::SYM_W-1:0]   r_s1_cell;
    logic [COL_W-1:0]             r_s1_addr;

    logic                         fire1;
    logic                         in_ready;
    logic                         accept;
    gpcc_pkg::t_counts            above_mem;
    gpcc_pkg::t_counts            result;

    logic                         r_out_valid;
    gpcc_pkg::t_count             r_out_count;

    gpcc_cfg_regs #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS),
        .ROW_SZ_W (ROW_SZ_W),
        .COL_SZ_W (COL_SZ_W)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_rows      (rows),
        .o_cols      (cols),
        .o_symbols   (symbols)
    );

    // Handshake: the update stage moves on unless its result cannot be stored.
    assign fire1    = r_s1_valid && (!r_s1_ctl.last_cell || !r_out_valid || o_count.ready);
    assign in_ready = !r_s1_valid || fire1;
    assign accept   = i_cell.valid && in_ready;
    assign i_cell.ready = in_ready;

    // End of row and end of grid for the cell at the current position.
    always_comb begin
        col_next = CMPC_W'(r_col_pos) + CMPC_W'(1);
        row_next = CMPR_W'(r_row_pos) + CMPR_W'(1);
        col_end  = col_next >= CMPC_W'(cols);
        row_end  = row_next >= CMPR_W'(rows);
    end

    // Position counters advance on every accepted beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_pos <= '0;
            r_row_pos <= '0;
        end else if (accept) begin
            if (col_end) begin
                r_col_pos <= '0;
                r_row_pos <= row_end ? '0 : ROW_W'(row_next);
            end else begin
                r_col_pos <= COL_W'(col_next);
            end
        end
    end

    // Stage register for the cell whose row buffer entry is being read.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (fire1) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_cell          <= i_cell.cell_char;
            r_s1_addr          <= r_col_pos;
            r_s1_ctl.has_above <= r_row_pos != '0;
            r_s1_ctl.has_left  <= r_col_pos != '0;
            r_s1_ctl.last_cell <= col_end && row_end;
            r_s1_ctl.forward   <= r_s1_valid && (r_s1_addr == r_col_pos);
        end
    end

    gpcc_row_mem #(
        .DEPTH (MAX_COLS),
        .WIDTH (3 * gpcc_pkg::COUNT_W),
        .AW    (COL_W)
    ) u_row_mem (
        .i_clk     (i_clk),
        .i_rd_en   (accept),
        .i_rd_addr (r_col_pos),
        .o_rd_data (above_mem),
        .i_wr_en   (fire1),
        .i_wr_addr (r_s1_addr),
        .i_wr_data (result)
    );

    gpcc_cell_update u_update (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire1),
        .i_ctl       (r_s1_ctl),
        .i_cell      (r_s1_cell),
        .i_symbols   (symbols),
        .i_above_mem (above_mem),
        .o_result    (result)
    );

    // Output register for the chain count beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            if (o_count.ready) begin
                r_out_valid <= 1'b0;
            end
            if (fire1 && r_s1_ctl.last_cell) begin
                r_out_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire1 && r_s1_ctl.last_cell) begin
            r_out_count <= result.triple;
        end
    end

    assign o_count.valid       = r_out_valid;
    assign o_count.chain_count = r_out_count;

endmodule

`default_nettype wire

// File: test/gpcc_checker.sv
// Checker that models the chain count of every grid and compares it with each count beat.
module gpcc_checker
    import gpcc_pkg::*;
#(
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int MAX_ROWS = DEF_MAX_ROWS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    gpcc_cell_if                       i_cell,
    gpcc_count_if                      i_count,
    output int                         o_fail_count,
    output int                         o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

    // Configuration as the block holds it.
    logic [SIZE_W-1:0] grid_rows;
    logic [SIZE_W-1:0] grid_cols;
    t_symbols          syms;

    // Counts of the previous row, of the previous cell and of its upper neighbor.
    t_counts           row_buf [MAX_COLS];
    t_counts           left_cnt;
    t_counts           diag_cnt;
    logic [ROW_W-1:0]  row_pos;
    logic [COL_W-1:0]  col_pos;

    t_count            chain_counts_due [$];
    int                fails = 0;

    // A size of zero means one, and a size above the buffer means the buffer.
    function automatic int clamp_dim(input logic [SIZE_W-1:0] v, input int max_dim);
        if (v == '0) return 1;
        if (int'(v) > max_dim) return max_dim;
        return int'(v);
    endfunction

    // Folds one cell into the dominance counts and queues the grid total on its last cell.
    function automatic void advance_cell(input logic [SYM_W-1:0] ch);
        t_counts up;
        t_counts lf;
        t_counts dg;
        t_counts nxt;
        int      rows_eff;
        int      cols_eff;
        rows_eff = clamp_dim(grid_rows, MAX_ROWS);
        cols_eff = clamp_dim(grid_cols, MAX_COLS);
        up = '0;
        lf = '0;
        dg = '0;
        if (row_pos != '0) up = row_buf[col_pos];
        if (col_pos != '0) begin
            lf = left_cnt;
            if (row_pos != '0) dg = diag_cnt;
        end

        // Each level is above plus left minus diagonal, plus the level below on a match.
        nxt.single = up.single + lf.single - dg.single;
        if (ch == syms.sym_first) nxt.single = nxt.single + 1'b1;
        nxt.pair = up.pair + lf.pair - dg.pair;
        if (ch == syms.sym_second) nxt.pair = nxt.pair + dg.single;
        nxt.triple = up.triple + lf.triple - dg.triple;
        if (ch == syms.sym_third) nxt.triple = nxt.triple + dg.pair;

        diag_cnt         = up;
        row_buf[col_pos] = nxt;
        left_cnt         = nxt;

        // The row and the grid end against the sizes in force now.
        if (int'(col_pos) + 1 >= cols_eff) begin
            col_pos = '0;
            if (int'(row_pos) + 1 >= rows_eff) begin
                row_pos = '0;
                chain_counts_due.push_back(nxt.triple);
            end else begin
                row_pos = row_pos + 1'b1;
            end
        end else begin
            col_pos = col_pos + 1'b1;
        end
    endfunction

    always @(posedge i_clk) begin
        t_count want;
        if (!i_rst_n) begin
            grid_rows       = RST_GRID_ROWS;
            grid_cols       = RST_GRID_COLS;
            syms.sym_first  = RST_FIRST;
            syms.sym_second = RST_SECOND;
            syms.sym_third  = RST_THIRD;
            left_cnt        = '0;
            diag_cnt        = '0;
            row_pos         = '0;
            col_pos         = '0;
            chain_counts_due.delete();
        end else begin
            // A count beat is matched against the oldest count still due.
            if (i_count.valid && i_count.ready) begin
                if (chain_counts_due.size() == 0) begin
                    $error("chain_count: expected no beat, actual %0d", i_count.chain_count);
                    fails++;
                end else begin
                    want = chain_counts_due.pop_front();
                    if (i_count.chain_count !== want) begin
                        $error("chain_count: expected %0d, actual %0d",
                               want, i_count.chain_count);
                        fails++;
                    end
                end
            end

            // Writes to indexes past the last register are dropped.
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_GRID_ROWS:     grid_rows = i_cfg_data[SIZE_W-1:0];
                    REG_GRID_COLS:     grid_cols = i_cfg_data[SIZE_W-1:0];
                    REG_FIRST_SYMBOL:  syms.sym_first = i_cfg_data[SYM_W-1:0];
                    REG_SECOND_SYMBOL: syms.sym_second = i_cfg_data[SYM_W-1:0];
                    REG_THIRD_SYMBOL:  syms.sym_third = i_cfg_data[SYM_W-1:0];
                    default: ;
                endcase
            end

            if (i_cell.valid && i_cell.ready) advance_cell(i_cell.cell_char);
        end
        o_fail_count <= fails;
        o_pending    <= chain_counts_due.size();
    end

endmodule

// File: test/tb_grid_pattern_chain_counter_top.sv
// Testbench top: feeds grids and register writes to the chain counter and reports the verdict.
module tb_grid_pattern_chain_counter_top;
    timeunit 1ns;
    timeprecision 1ps;
    import gpcc_pkg::*;

    localparam int RESET_CYCLES   = 7;
    localparam int RAND_ITEMS     = 580;
    localparam int CALM_ITEMS     = 150;
    localparam int MIN_GRIDS      = 20;
    localparam int DRAIN_CYCLES   = 8;
    localparam int HOLD_CYCLES    = 300;
    localparam int PRESSURE_CELLS = 40;
    localparam int TALL_CELLS     = 16;
    localparam int TIMEOUT_NS     = 1000000;

    // First index past the register file; writes there must be ignored.
    localparam int FIRST_SPARE_REG = REG_THIRD_SYMBOL + 1;
    // Size above the buffer, taken by the block as its maximum.
    localparam int OVER_SIZE       = 2 ** SIZE_W - 1;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    int                    fail_count;
    int                    pending;

    gpcc_cell_if  cell_bus ();
    gpcc_count_if count_bus ();

    // Stimulus state; calm and hold_requests are shared with the count side.
    bit       calm = 1'b0;
    int       hold_requests = 0;
    t_symbols cur_syms;

    always #2 i_clk = ~i_clk;

    grid_pattern_chain_counter_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cell      (cell_bus),
        .o_count     (count_bus)
    );

    gpcc_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_cell       (cell_bus),
        .i_count      (count_bus),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // One register write, with the enable low again before the next one can start.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic set_grid(input int rows, input int cols);
        write_reg(REG_GRID_ROWS, CFG_DATA_W'(rows));
        write_reg(REG_GRID_COLS, CFG_DATA_W'(cols));
    endtask

    // Bits above the symbol width are filled at random; the block must drop them.
    task automatic set_symbols(input logic [SYM_W-1:0] a, input logic [SYM_W-1:0] b,
                               input logic [SYM_W-1:0] c);
        logic [CFG_DATA_W-SYM_W-1:0] pad;
        pad = (CFG_DATA_W - SYM_W)'($urandom_range(0, 2 ** (CFG_DATA_W - SYM_W) - 1));
        write_reg(REG_FIRST_SYMBOL, {pad, a});
        pad = (CFG_DATA_W - SYM_W)'($urandom_range(0, 2 ** (CFG_DATA_W - SYM_W) - 1));
        write_reg(REG_SECOND_SYMBOL, {pad, b});
        pad = (CFG_DATA_W - SYM_W)'($urandom_range(0, 2 ** (CFG_DATA_W - SYM_W) - 1));
        write_reg(REG_THIRD_SYMBOL, {pad, c});
        cur_syms.sym_first  = a;
        cur_syms.sym_second = b;
        cur_syms.sym_third  = c;
    endtask

    // Offers one cell beat, after an optional gap, and returns at the edge that takes it.
    task automatic send_cell(input logic [SYM_W-1:0] ch);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 6);
            cell_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cell_bus.valid     <= 1'b1;
        cell_bus.cell_char <= ch;
        do @(posedge i_clk); while (!cell_bus.ready);
    endtask

    // Well-formed content is mostly the pattern symbols; noise is any code.
    function automatic logic [SYM_W-1:0] pick_cell(input bit well);
        if (well && $urandom_range(0, 9) < 8) begin
            case ($urandom_range(0, 2))
                0:       return cur_syms.sym_first;
                1:       return cur_syms.sym_second;
                default: return cur_syms.sym_third;
            endcase
        end
        return SYM_W'($urandom_range(0, 255));
    endfunction

    task automatic send_cells(input int n, input bit well);
        repeat (n) send_cell(pick_cell(well));
    endtask

    // Drops valid, waits for every count due, then lets the pipeline drain.
    task automatic wait_idle();
        cell_bus.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Count side: random stall bursts, plus one long hold-off on request.
    initial begin
        int stall_left;
        int holds_done;
        stall_left = 0;
        holds_done = 0;
        count_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                count_bus.ready <= 1'b0;
            end else if (holds_done != hold_requests) begin
                holds_done++;
                stall_left = HOLD_CYCLES - 1;
                count_bus.ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(0, 5);
                count_bus.ready <= 1'b0;
            end else begin
                count_bus.ready <= 1'b1;
            end
        end
    end

    // Watchdog for a run that hangs.
    initial begin
        #(TIMEOUT_NS);
        $display("simulation failed");
        $finish;
    end

    // Cell side and register writes.
    initial begin
        int               small_items;
        int               grids_done;
        int               rows;
        int               cols;
        int               n;
        bit               well;
        bit               broken;
        bit               pressed;
        logic [SYM_W-1:0] a;
        logic [SYM_W-1:0] b;
        logic [SYM_W-1:0] c;

        small_items = 0;
        grids_done  = 0;
        pressed     = 1'b0;
        cur_syms.sym_first  = RST_FIRST;
        cur_syms.sym_second = RST_SECOND;
        cur_syms.sym_third  = RST_THIRD;

        i_rst_n            <= 1'b0;
        i_cfg_we           <= 1'b0;
        i_cfg_index        <= '0;
        i_cfg_data         <= '0;
        cell_bus.valid     <= 1'b0;
        cell_bus.cell_char <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // A small grid with chains, holding the lowest and highest cell codes as well.
        set_grid(3, 3);
        set_symbols(RST_FIRST, RST_SECOND, RST_THIRD);
        send_cell(cur_syms.sym_first);
        send_cell(8'hFF);
        send_cell(cur_syms.sym_second);
        send_cell(8'h00);
        send_cell(cur_syms.sym_second);
        send_cell(cur_syms.sym_first);
        repeat (3) send_cell(cur_syms.sym_third);
        wait_idle();

        // Zero sizes act as a grid of one cell, so every cell ends a grid.
        set_grid(0, 0);
        send_cell(8'h00);
        send_cell(8'hFF);
        wait_idle();

        // All three symbols equal, with the column count shrunk mid-grid and then restored.
        set_symbols(8'hFF, 8'hFF, 8'hFF);
        set_grid(3, 3);
        repeat (4) send_cell(8'hFF);
        wait_idle();
        set_grid(3, 1);
        send_cell(8'hFF);
        wait_idle();
        set_grid(3, 3);
        repeat (3) send_cell(8'hFF);
        wait_idle();

        // Writes past the register file, then a row count shrunk mid-grid.
        for (int idx = FIRST_SPARE_REG; idx < 2 ** CFG_IDX_W; idx++) begin
            write_reg(CFG_IDX_W'(idx), CFG_DATA_W'($urandom_range(0, OVER_SIZE)));
        end
        set_symbols(8'h00, 8'h01, 8'h02);
        set_grid(4, 2);
        send_cells(4, 1'b1);
        wait_idle();
        set_grid(1, 2);
        send_cells(2, 1'b1);
        wait_idle();

        // One full-width row writes every row buffer entry; after it any resize is safe.
        set_grid(1, OVER_SIZE);
        send_cells(DEF_MAX_COLS, 1'b1);
        wait_idle();

        // An oversized row count must not end a tall grid early; a one-cell grid closes it.
        set_grid(OVER_SIZE, 1);
        send_cells(TALL_CELLS, 1'b1);
        wait_idle();
        set_grid(0, 0);
        send_cell(pick_cell(1'b1));
        wait_idle();

        // Random grids, mostly well formed, some cut short or overrun.
        while (small_items < RAND_ITEMS || grids_done < MIN_GRIDS) begin
            if (small_items >= RAND_ITEMS - CALM_ITEMS) calm = 1'b1;

            if (!pressed && small_items >= RAND_ITEMS / 2) begin
                // The count side holds off for a long stretch while cells keep coming.
                pressed = 1'b1;
                set_grid(1, 2);
                hold_requests++;
                send_cells(PRESSURE_CELLS, 1'b1);
                small_items += PRESSURE_CELLS;
                wait_idle();
            end

            if ($urandom_range(0, 2) == 0) begin
                a = SYM_W'($urandom_range(0, 255));
                b = SYM_W'($urandom_range(0, 255));
                c = SYM_W'($urandom_range(0, 255));
                if ($urandom_range(0, 4) == 0) b = a;
                if ($urandom_range(0, 4) == 0) c = b;
                set_symbols(a, b, c);
            end

            case ($urandom_range(0, 9))
                0:       rows = 0;
                1:       rows = $urandom_range(7, 10);
                default: rows = $urandom_range(1, 6);
            endcase
            case ($urandom_range(0, 9))
                0:       cols = 0;
                1:       cols = $urandom_range(9, 24);
                default: cols = $urandom_range(1, 8);
            endcase
            set_grid(rows, cols);

            n      = ((rows == 0) ? 1 : rows) * ((cols == 0) ? 1 : cols);
            well   = ($urandom_range(0, 7) != 0);
            broken = ($urandom_range(0, 9) == 0);
            if (broken) n = $urandom_range(1, 2 * n);
            send_cells(n, well);
            small_items += n;
            wait_idle();

            if (broken) begin
                // Resize in the middle of a grid, then a one-cell grid closes what is open.
                set_grid($urandom_range(1, 6), $urandom_range(1, 8));
                n = $urandom_range(1, 6);
                send_cells(n, well);
                small_items += n;
                wait_idle();
                set_grid(0, 0);
                send_cell(pick_cell(well));
                small_items++;
                wait_idle();
            end
            grids_done++;
        end

        if (fail_count == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
